// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the lottery slot picker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/lsp_pkg.sv =====
// Types and constants of the lottery slot picker
package lsp_pkg;

    localparam int ACC_W = 16;          // running ticket sum, up to 256 slots
    localparam int IDX_W = 8;           // slot index inside the chain
    localparam int GEN_W = 31;
    localparam int PROD_W = 47;
    localparam logic [GEN_W-1:0] PM_MOD = 31'h7fffffff;
    localparam logic [15:0] PM_MULT = 16'd48271;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_SUM,
        ST_MOD,
        ST_WSTART,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             vld;
        logic             walk;
        logic [ACC_W-1:0] acc;
        logic             found;
        logic [IDX_W-1:0] win;
    } t_tok;

endpackage

// ===== hw/rtl/lsp_cell.sv =====
// One slot of the chain: stored entry plus one token stage
module lsp_cell #(
    parameter int IDX = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [lsp_pkg::IDX_W-1:0] i_wr_slot,
    input  logic [7:0]             i_wr_tickets,
    input  logic                   i_wr_runnable,
    input  logic [lsp_pkg::ACC_W-1:0] i_winning,
    input  lsp_pkg::t_tok          i_tok,
    output lsp_pkg::t_tok          o_tok
);
    import lsp_pkg::*;

    logic [7:0]       r_tickets;
    logic             r_run;
    t_tok             r_tok;
    t_tok             n_tok;
    logic [ACC_W-1:0] w_add;
    logic             w_hit;

    always_comb begin
        w_add = i_tok.acc + (r_run ? ACC_W'(r_tickets) : '0);
        w_hit = i_tok.walk && r_run && !i_tok.found && (w_add > i_winning);
        n_tok       = i_tok;
        n_tok.acc   = w_add;
        n_tok.found = i_tok.found | w_hit;
        n_tok.win   = w_hit ? IDX_W'(IDX) : i_tok.win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tickets <= '0;
            r_run     <= 1'b0;
            r_tok     <= '0;
        end else begin
            if (i_wr_en && i_wr_slot == IDX_W'(IDX)) begin
                r_tickets <= i_wr_tickets;
                r_run     <= i_wr_runnable;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/lsp_mod.sv =====
// Restoring remainder unit, one quotient bit per cycle
module lsp_mod (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [lsp_pkg::GEN_W-1:0] i_dividend,
    input  logic [lsp_pkg::ACC_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [lsp_pkg::ACC_W-1:0] o_rem
);
    import lsp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [GEN_W-1:0] r_dvd;
    logic [ACC_W-1:0] r_rem;
    logic [ACC_W:0]   w_trial;
    logic [ACC_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[GEN_W-1]};
        if (w_trial >= {1'b0, i_divisor}) begin
            n_rem = ACC_W'(w_trial - {1'b0, i_divisor});
        end else begin
            n_rem = w_trial[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(GEN_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[GEN_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== hw/rtl/lottery_slot_picker.sv =====
// Lottery slot picker: slot chain, Park-Miller generator and control
//
// channel  direction  signals
// in       sink       i_in_valid / o_in_ready, i_op i_slot i_tickets i_runnable
// out      source     o_out_valid / i_out_ready, o_winner o_found o_random_value
//                     o_total_tickets
//
// A write goes straight into its slot. A draw makes two token passes through the
// slot chain, a sum pass and a walk pass, with the remainder unit in between.
// With no runnable tickets a draw skips the remainder and the walk. Reset clears
// every slot and seeds the generator with one.
// A finished draw waits in the output register; a following draw can run meanwhile
// and stalls at its end only if that register is still full.
module lottery_slot_picker #(
    parameter int SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [5:0]  i_slot,
    input  logic [7:0]  i_tickets,
    input  logic        i_runnable,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_winner,
    output logic        o_found,
    output logic [30:0] o_random_value,
    output logic [13:0] o_total_tickets
);
    import lsp_pkg::*;
    `include "assert_macros.svh"

    t_state            r_state, n_state;
    logic [GEN_W-1:0]  r_gen;
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_total;
    logic [ACC_W-1:0]  r_winning;
    logic              r_found;
    logic [IDX_W-1:0]  r_win;
    logic              r_out_valid;
    logic [5:0]        r_o_winner;
    logic              r_o_found;
    logic [GEN_W-1:0]  r_o_rnd;
    logic [13:0]       r_o_total;

    logic              w_accept, w_wr_en, w_load, w_div_start, w_div_done;
    logic [ACC_W-1:0]  w_rem;
    logic [GEN_W:0]    w_fold;
    logic [GEN_W-1:0]  w_next_gen;
    t_tok              w_head;
    t_tok              w_link [0:SLOTS];
    t_tok              w_tail;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_wr_en   = w_accept && i_op == OP_WRITE;
    assign w_link[0] = w_head;
    assign w_tail    = w_link[SLOTS];

    // Mersenne fold of the product
    always_comb begin
        w_fold = {1'b0, r_prod[GEN_W-1:0]} + (GEN_W+1)'(r_prod[PROD_W-1:GEN_W]);
        if (w_fold >= {1'b0, PM_MOD}) begin
            w_next_gen = GEN_W'(w_fold - {1'b0, PM_MOD});
        end else begin
            w_next_gen = w_fold[GEN_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        w_head      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_accept && i_op == OP_DRAW) n_state = ST_GEN;
            end
            ST_GEN: begin
                w_head.vld = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (w_tail.vld) begin
                    if (w_tail.acc == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (w_div_done) n_state = ST_WSTART;
            end
            ST_WSTART: begin
                w_head.vld  = 1'b1;
                w_head.walk = 1'b1;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (w_tail.vld) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gen       <= GEN_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_GEN) r_gen <= w_next_gen;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_prod <= PROD_W'(r_gen) * PROD_W'(PM_MULT);
        if (r_state == ST_SUM && w_tail.vld) begin
            r_total <= w_tail.acc;
            r_found <= 1'b0;
            r_win   <= '0;
        end
        if (r_state == ST_MOD && w_div_done) r_winning <= w_rem;
        if (r_state == ST_WALK && w_tail.vld) begin
            r_found <= w_tail.found;
            r_win   <= w_tail.found ? w_tail.win : '0;
        end
        if (w_load) begin
            r_o_winner <= r_win[5:0];
            r_o_found  <= r_found;
            r_o_rnd    <= r_gen;
            r_o_total  <= r_total[13:0];
        end
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lsp_cell #(.IDX(g)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_wr_en       (w_wr_en),
            .i_wr_slot     (IDX_W'(i_slot)),
            .i_wr_tickets  (i_tickets),
            .i_wr_runnable (i_runnable),
            .i_winning     (r_winning),
            .i_tok         (w_link[g]),
            .o_tok         (w_link[g+1])
        );
    end

    // The sum token has left the chain by now; hold the divisor in r_total
    lsp_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_gen),
        .i_divisor  (r_total),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign o_out_valid     = r_out_valid;
    assign o_winner        = r_o_winner;
    assign o_found         = r_o_found;
    assign o_random_value  = r_o_rnd;
    assign o_total_tickets = r_o_total;

    `ASSERT_IMPL(a_tok_phase, w_tail.vld, r_state == ST_SUM || r_state == ST_WALK)
    `ASSERT_IMPL(a_div_phase, w_div_done, r_state == ST_MOD)
    `ASSERT_NEXT(a_gen_nonzero, r_state == ST_GEN, r_gen != '0)

endmodule

// ===== tb/tb_lottery_slot_picker.sv =====
// Testbench for the lottery slot picker: random and directed slot writes and draws
`timescale 1ns / 100ps

module tb_lottery_slot_picker;
    import lsp_pkg::*;

    localparam int NSLOT = 64;
    localparam longint CYCLE_LIMIT = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic [5:0]  i_slot;
    logic [7:0]  i_tickets;
    logic        i_runnable;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_winner;
    logic        o_found;
    logic [30:0] o_random_value;
    logic [13:0] o_total_tickets;

    lottery_slot_picker dut (.*);

    typedef struct packed {
        logic [5:0]  winner;
        logic        found;
        logic [30:0] rnd;
        logic [13:0] total;
    } t_draw;

    logic [7:0]  ticket_mirror[NSLOT];
    logic        run_mirror[NSLOT];
    logic [30:0] lfsr_mirror;
    t_draw       pending_draws[$];

    int          mismatches;
    int          draws_seen;
    int          items_sent;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    longint      cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the generator and settle the winner as the scheduler should
    function automatic t_draw pick_winner();
        t_draw       d;
        logic [63:0] prod;
        int          sum;
        int          win_tix;
        int          running;
        prod = 64'(lfsr_mirror) * 64'd48271;
        lfsr_mirror = 31'(prod % 64'h7fffffff);
        if (lfsr_mirror == 0) lfsr_mirror = 1;
        sum = 0;
        for (int i = 0; i < NSLOT; i++)
            if (run_mirror[i]) sum += ticket_mirror[i];
        d = '0;
        d.rnd = lfsr_mirror;
        d.total = 14'(sum);
        if (sum != 0) begin
            win_tix = int'(32'(lfsr_mirror) % 32'(sum));
            running = 0;
            for (int i = 0; i < NSLOT; i++) begin
                if (!run_mirror[i]) continue;
                running += ticket_mirror[i];
                if (running > win_tix) begin
                    d.winner = 6'(i);
                    d.found = 1'b1;
                    break;
                end
            end
        end
        return d;
    endfunction

    // Valid stays high after acceptance unless the sender idles before the next one
    task automatic send_item(input logic op, input logic [5:0] slot,
                             input logic [7:0] tix, input logic run);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_slot     <= slot;
        i_tickets  <= tix;
        i_runnable <= run;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == OP_DRAW) begin
            pending_draws.push_back(pick_winner());
        end else begin
            ticket_mirror[slot] = tix;
            run_mirror[slot] = run;
        end
        items_sent++;
    endtask

    task automatic write_slot(input int s, input int t, input logic r);
        send_item(OP_WRITE, 6'(s), 8'(t), r);
    endtask

    task automatic draw();
        send_item(OP_DRAW, 6'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic test_empty_table();
        draw();
        write_slot(5, 200, 1'b0);
        draw();
    endtask

    task automatic test_extremes();
        write_slot(0, 255, 1'b1);
        draw();
        write_slot(63, 255, 1'b1);
        draw();
        write_slot(0, 0, 1'b1);
        draw();
        write_slot(63, 1, 1'b1);
        draw();
        write_slot(31, 170, 1'b0);
        write_slot(42, 85, 1'b1);
        draw();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < NSLOT; i++) write_slot(i, 255, 1'b1);
        draw();
        draw();
    endtask

    task automatic test_random(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(99) < 30) draw();
            else write_slot(int'($urandom_range(63)), ($urandom_range(3) == 0) ? 0 :
                            int'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // Stall the output for a long stretch while draws keep coming
    task automatic test_back_pressure();
        hold_off = 3000;
        repeat (8) draw();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off    <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_draw exp_d;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            draws_seen++;
            if (pending_draws.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected draw result at %0t: got w=%0d f=%0b r=%0d t=%0d",
                             $time, o_winner, o_found, o_random_value, o_total_tickets);
            end else begin
                exp_d = pending_draws.pop_front();
                if (o_winner !== exp_d.winner || o_found !== exp_d.found ||
                    o_random_value !== exp_d.rnd || o_total_tickets !== exp_d.total) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Draw mismatch: exp w=%0d f=%0b r=%0d t=%0d, got w=%0d f=%0b r=%0d t=%0d",
                                 exp_d.winner, exp_d.found, exp_d.rnd, exp_d.total,
                                 o_winner, o_found, o_random_value, o_total_tickets);
                end
            end
        end
    end

    initial begin
        cycles = 0; mismatches = 0; draws_seen = 0; items_sent = 0; hold_off = 0;
        send_idle_pct = 12; recv_idle_pct = 49;
        lfsr_mirror = 31'd1;
        for (int i = 0; i < NSLOT; i++) begin
            ticket_mirror[i] = '0;
            run_mirror[i] = 1'b0;
        end
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_op = OP_WRITE;
        i_slot = '0; i_tickets = '0; i_runnable = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_extremes();
        test_full_table();
        test_back_pressure();
        test_random(360);
        send_idle_pct = 49; recv_idle_pct = 12;
        test_random(360);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(360);

        drain();
        repeat (200) @(posedge i_clk);
        $display("Sent %0d transactions, checked %0d draws, incl. empty table, full table",
                 items_sent, draws_seen);
        $display("and a long output stall; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_draws.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_cell.sv
hw/rtl/lsp_mod.sv
hw/rtl/lottery_slot_picker.sv
tb/tb_lottery_slot_picker.sv
